// ----- design/tms_pkg.sv -----
package tms_pkg;

  localparam int PROG_DEPTH_DEF  = 4096;
  localparam int TAPE_DEPTH_DEF  = 1024;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STEP   = 2'd1;
  localparam logic [1:0] CMD_SUPPLY = 2'd2;
  localparam logic [1:0] CMD_INTR   = 2'd3;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_OUT  = 3'd1;
  localparam logic [2:0] KIND_WAIT = 3'd2;
  localparam logic [2:0] KIND_STOP = 3'd3;
  localparam logic [2:0] KIND_LOOP = 3'd4;
  localparam logic [2:0] KIND_OVF  = 3'd5;

  localparam logic [7:0] OP_DEC   = 8'h2d;
  localparam logic [7:0] OP_INC   = 8'h2b;
  localparam logic [7:0] OP_IN    = 8'h2c;
  localparam logic [7:0] OP_OUT   = 8'h2e;
  localparam logic [7:0] OP_OPEN  = 8'h5b;
  localparam logic [7:0] OP_CLOSE = 8'h5d;
  localparam logic [7:0] OP_LEFT  = 8'h3c;
  localparam logic [7:0] OP_RIGHT = 8'h3e;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SKIP
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic take_item;
    logic run_exec;
    logic run_skip;
  } ctl_t;

  typedef struct packed {
    logic clear_done;
    logic halted;
    logic at_end;
    logic exec_term;
    logic skip_done;
  } stat_t;

  function automatic logic is_op(input logic [7:0] b);
    return b == OP_DEC || b == OP_INC || b == OP_IN || b == OP_OUT ||
           b == OP_OPEN || b == OP_CLOSE || b == OP_LEFT || b == OP_RIGHT;
  endfunction

endpackage

// ----- design/tape_machine_stepper_unit.sv -----
// Channel   Signals                         Handshake
// item in   cmd, data_byte                  start while busy is low
// result    kind, out_byte                  done, one cycle, cannot be held off
//
// Load, supply and interrupt: result on done one cycle after the item is taken.
// Step: the instruction executes, then non-instruction bytes after it are skipped;
// no skip when it stops or waits on the instruction itself, and no execution when
// already stopped or at program end. The skip walks the program RAM one byte per
// cycle. After reset the tape RAM is cleared, one cell a cycle, with busy held high.
module tape_machine_stepper_unit #(
  parameter int PROG_DEPTH  = tms_pkg::PROG_DEPTH_DEF,
  parameter int TAPE_DEPTH  = tms_pkg::TAPE_DEPTH_DEF,
  parameter int STACK_DEPTH = tms_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  output logic       done,
  output logic [2:0] kind,
  output logic [7:0] out_byte
);

  tms_pkg::ctl_t  ctl;
  tms_pkg::stat_t stat;

  tms_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  tms_dp #(
    .PROG_DEPTH  (PROG_DEPTH),
    .TAPE_DEPTH  (TAPE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cmd       (cmd),
    .data_byte (data_byte),
    .stat      (stat),
    .done      (done),
    .kind      (kind),
    .out_byte  (out_byte)
  );

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> busy)
    else $error("not clearing after reset");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd != tms_pkg::CMD_STEP) |=> done)
    else $error("missing result for load, supply or interrupt");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (done && kind != tms_pkg::KIND_OUT) |-> out_byte == 8'd0)
    else $error("out_byte set without output kind");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    done |-> kind <= tms_pkg::KIND_OVF)
    else $error("kind out of range");

endmodule

// ----- design/tms_ram.sv -----
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tms_ctrl.sv -----
module tms_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         cmd,
  input  tms_pkg::stat_t     stat,
  output tms_pkg::ctl_t      ctl,
  output logic               busy
);

  tms_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tms_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tms_pkg::ST_CLEAR: begin
        if (stat.clear_done) state_next = tms_pkg::ST_IDLE;
      end
      tms_pkg::ST_IDLE: begin
        if (start && cmd == tms_pkg::CMD_STEP && !stat.halted && !stat.at_end) begin
          state_next = tms_pkg::ST_EXEC;
        end
      end
      tms_pkg::ST_EXEC: begin
        state_next = stat.exec_term ? tms_pkg::ST_IDLE : tms_pkg::ST_SKIP;
      end
      tms_pkg::ST_SKIP: begin
        if (stat.skip_done) state_next = tms_pkg::ST_IDLE;
      end
      default: state_next = tms_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state)
      tms_pkg::ST_CLEAR: ctl.clear_step = 1'b1;
      tms_pkg::ST_IDLE: begin
        busy          = 1'b0;
        ctl.take_item = start;
      end
      tms_pkg::ST_EXEC: ctl.run_exec = 1'b1;
      tms_pkg::ST_SKIP: ctl.run_skip = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule

// ----- design/tms_dp.sv -----
module tms_dp #(
  parameter int PROG_DEPTH  = tms_pkg::PROG_DEPTH_DEF,
  parameter int TAPE_DEPTH  = tms_pkg::TAPE_DEPTH_DEF,
  parameter int STACK_DEPTH = tms_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  tms_pkg::ctl_t  ctl,
  input  logic [1:0]     cmd,
  input  logic [7:0]     data_byte,
  output tms_pkg::stat_t stat,
  output logic           done,
  output logic [2:0]     kind,
  output logic [7:0]     out_byte
);

  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int LW  = PAW + 1;
  localparam int HW  = $clog2(TAPE_DEPTH);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int DW  = SW + 1;

  logic [LW-1:0]  len, len_next, ip, ip_next, ip_base;
  logic [HW-1:0]  head, head_next, clr_cnt, clr_cnt_next;
  logic [DW-1:0]  depth, depth_next, depth_m1;
  logic           halted, halted_next, ready, ready_next;
  logic [7:0]     hold, hold_next;
  logic [2:0]     pend_kind, pend_kind_next, kind_next;
  logic [7:0]     pend_byte, pend_byte_next, out_byte_next;
  logic           done_next;

  logic [7:0]     prog_rd, tape_rd;
  logic [PAW-1:0] stack_rd;
  logic           prog_we, tape_we;
  logic [7:0]     tape_wdata;
  logic [HW-1:0]  tape_waddr;

  // decode of the instruction in flight
  logic           x_term, x_halt, x_cell_we, x_jump, x_emit, x_push, x_ready_clr;
  logic [2:0]     x_kind;
  logic [7:0]     x_cell;
  logic [HW-1:0]  x_head;
  logic [DW-1:0]  x_depth;

  logic full, at_end, stack_full;

  assign full       = len == LW'(PROG_DEPTH);
  assign at_end     = ip >= len;
  assign stack_full = depth == DW'(STACK_DEPTH);

  assign stat.clear_done = clr_cnt == HW'(TAPE_DEPTH - 1);
  assign stat.halted     = halted;
  assign stat.at_end     = at_end;
  assign stat.exec_term  = x_term;
  assign stat.skip_done  = at_end || tms_pkg::is_op(prog_rd);

  always_comb begin
    x_term      = 1'b0;
    x_halt      = 1'b0;
    x_kind      = tms_pkg::KIND_NONE;
    x_cell_we   = 1'b0;
    x_cell      = tape_rd;
    x_head      = head;
    x_depth     = depth;
    x_jump      = 1'b0;
    x_emit      = 1'b0;
    x_push      = 1'b0;
    x_ready_clr = 1'b0;
    case (prog_rd)
      tms_pkg::OP_INC: begin
        x_cell_we = 1'b1;
        x_cell    = tape_rd + 8'd1;
      end
      tms_pkg::OP_DEC: begin
        x_cell_we = 1'b1;
        x_cell    = tape_rd - 8'd1;
      end
      tms_pkg::OP_RIGHT: begin
        x_head = (head == HW'(TAPE_DEPTH - 1)) ? '0 : head + HW'(1);
      end
      tms_pkg::OP_LEFT: begin
        x_head = (head == '0) ? HW'(TAPE_DEPTH - 1) : head - HW'(1);
      end
      tms_pkg::OP_IN: begin
        if (!ready) begin
          x_term = 1'b1;
          x_kind = tms_pkg::KIND_WAIT;
        end else begin
          x_ready_clr = 1'b1;
          x_cell_we   = 1'b1;
          x_cell      = (hold >= tms_pkg::CHAR_ZERO && hold <= tms_pkg::CHAR_NINE)
                        ? hold - tms_pkg::CHAR_ZERO : hold;
        end
      end
      tms_pkg::OP_OUT: x_emit = 1'b1;
      tms_pkg::OP_OPEN: begin
        if (stack_full) begin
          x_term = 1'b1;
          x_halt = 1'b1;
          x_kind = tms_pkg::KIND_OVF;
        end else begin
          x_push  = 1'b1;
          x_depth = depth + DW'(1);
        end
      end
      tms_pkg::OP_CLOSE: begin
        if (depth == '0) begin
          x_term = 1'b1;
          x_halt = 1'b1;
          x_kind = tms_pkg::KIND_LOOP;
        end else if (tape_rd != 8'd0) begin
          x_jump = 1'b1;
        end else begin
          x_depth = depth - DW'(1);
        end
      end
      default: begin
        x_term = 1'b1;
        x_halt = 1'b1;
        x_kind = tms_pkg::KIND_STOP;
      end
    endcase
  end

  assign ip_base = x_jump ? {1'b0, stack_rd} : ip;

  always_comb begin
    len_next       = len;
    ip_next        = ip;
    head_next      = head;
    depth_next     = depth;
    halted_next    = halted;
    ready_next     = ready;
    hold_next      = hold;
    clr_cnt_next   = clr_cnt;
    pend_kind_next = pend_kind;
    pend_byte_next = pend_byte;
    done_next      = 1'b0;
    kind_next      = kind;
    out_byte_next  = 8'd0;
    prog_we        = 1'b0;

    if (ctl.clear_step) begin
      clr_cnt_next = clr_cnt + HW'(1);
    end

    if (ctl.take_item) begin
      kind_next = tms_pkg::KIND_NONE;
      case (cmd)
        tms_pkg::CMD_LOAD: begin
          done_next = 1'b1;
          if (full) begin
            kind_next = tms_pkg::KIND_OVF;
          end else begin
            prog_we  = 1'b1;
            len_next = len + LW'(1);
          end
        end
        tms_pkg::CMD_STEP: begin
          if (halted || at_end) begin
            done_next   = 1'b1;
            halted_next = 1'b1;
            kind_next   = tms_pkg::KIND_STOP;
          end
        end
        tms_pkg::CMD_SUPPLY: begin
          done_next  = 1'b1;
          hold_next  = data_byte;
          ready_next = 1'b1;
        end
        tms_pkg::CMD_INTR: begin
          done_next   = 1'b1;
          halted_next = 1'b1;
          kind_next   = tms_pkg::KIND_STOP;
        end
        default: done_next = 1'b0;
      endcase
    end

    if (ctl.run_exec) begin
      if (x_term) begin
        done_next = 1'b1;
        kind_next = x_kind;
        if (x_halt) halted_next = 1'b1;
      end else begin
        head_next      = x_head;
        depth_next     = x_depth;
        ip_next        = ip_base + LW'(1);
        if (x_ready_clr) ready_next = 1'b0;
        pend_kind_next = x_emit ? tms_pkg::KIND_OUT : tms_pkg::KIND_NONE;
        pend_byte_next = x_emit ? tape_rd : 8'd0;
      end
    end

    if (ctl.run_skip) begin
      if (stat.skip_done) begin
        done_next     = 1'b1;
        kind_next     = pend_kind;
        out_byte_next = pend_byte;
      end else begin
        ip_next = ip + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      ip      <= '0;
      head    <= '0;
      depth   <= '0;
      halted  <= 1'b0;
      ready   <= 1'b0;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      len     <= len_next;
      ip      <= ip_next;
      head    <= head_next;
      depth   <= depth_next;
      halted  <= halted_next;
      ready   <= ready_next;
      clr_cnt <= clr_cnt_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    hold      <= hold_next;
    pend_kind <= pend_kind_next;
    pend_byte <= pend_byte_next;
    kind      <= kind_next;
    out_byte  <= out_byte_next;
  end

  // reads track the next pointer values, so data is ready in the following cycle
  assign depth_m1   = depth_next - DW'(1);
  assign tape_we    = ctl.clear_step || (ctl.run_exec && !x_term && x_cell_we);
  assign tape_waddr = ctl.clear_step ? clr_cnt : head;
  assign tape_wdata = ctl.clear_step ? 8'd0 : x_cell;

  tms_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (len[PAW-1:0]),
    .wdata (data_byte),
    .raddr (ip_next[PAW-1:0]),
    .rdata (prog_rd)
  );

  tms_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (head_next),
    .rdata (tape_rd)
  );

  tms_ram #(.WIDTH(PAW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ctl.run_exec && x_push),
    .waddr (depth[SW-1:0]),
    .wdata (ip[PAW-1:0]),
    .raddr (depth_m1[SW-1:0]),
    .rdata (stack_rd)
  );

endmodule
